>>> src/bbc_pkg.sv
// ---------------------------------------------------------------------------
// bbc_pkg
// Shared types, constants and character decode for the bracket balance
// checker.
// ---------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_WRONG    = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_UNCLOSED = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    // Bracket kinds as shown on expected_kind
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_PAREN  = 3'd1;
    localparam logic [2:0] KIND_BRACE  = 3'd2;
    localparam logic [2:0] KIND_SQUARE = 3'd3;
    localparam logic [2:0] KIND_ANGLE  = 3'd4;

    // Bracket characters
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_LANGLE  = 8'h3C;
    localparam logic [7:0] CH_RANGLE  = 8'h3E;

    // One result item
    typedef struct packed {
        logic [2:0] status;
        logic [2:0] expected_kind;
        logic [6:0] depth;
    } result_t;

    // Stack memory write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [1:0]        kind;
    } stk_wr_t;

    // Kind of an opener, KIND_NONE for anything else
    function automatic logic [2:0] opener_kind(input logic [7:0] c);
        logic [2:0] k;
        unique case (c)
            CH_LPAREN:  k = KIND_PAREN;
            CH_LBRACE:  k = KIND_BRACE;
            CH_LSQUARE: k = KIND_SQUARE;
            CH_LANGLE:  k = KIND_ANGLE;
            default:    k = KIND_NONE;
        endcase
        return k;
    endfunction

    // Kind of a closer, KIND_NONE for anything else
    function automatic logic [2:0] closer_kind(input logic [7:0] c);
        logic [2:0] k;
        unique case (c)
            CH_RPAREN:  k = KIND_PAREN;
            CH_RBRACE:  k = KIND_BRACE;
            CH_RSQUARE: k = KIND_SQUARE;
            CH_RANGLE:  k = KIND_ANGLE;
            default:    k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

>>> src/bbc_stack_mem.sv
// ---------------------------------------------------------------------------
// bbc_stack_mem
// Bracket kind stack storage: one write port, one read port with a
// registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module bbc_stack_mem (
    input  wire logic                      clk,
    input  wire bbc_pkg::stk_wr_t          wr,
    input  wire logic [bbc_pkg::ADDR_W-1:0] rd_addr,
    output logic [1:0]                     rd_kind
);

    logic [1:0] kind_mem [bbc_pkg::STACK_DEPTH];
    logic [1:0] rd_kind_reg;

    // Write the pushed kind
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            kind_mem[wr.addr] <= wr.kind;
        end
    end

    // Read every cycle
    always_ff @(posedge clk)
    begin
        rd_kind_reg <= kind_mem[rd_addr];
    end

    assign rd_kind = rd_kind_reg;

endmodule

`default_nettype wire

>>> src/bbc_out_fifo.sv
// ---------------------------------------------------------------------------
// bbc_out_fifo
// Two-entry result buffer between the stack logic and the output channel.
// ---------------------------------------------------------------------------
`default_nettype none

module bbc_out_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire bbc_pkg::result_t push_data,
    output logic                  full,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output bbc_pkg::result_t      out_data
);

    bbc_pkg::result_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       pop;

    assign pop = (fill_reg != 2'd0) && !out_stall;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the incoming result
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (fill_reg == 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

>>> src/bracket_balance_checker.sv
// ---------------------------------------------------------------------------
// bracket_balance_checker
// Checks bracket nesting over a character stream with a bounded kind stack.
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in      | sink      | in_valid / in_stall | ch, end_of_text
//  out     | source    | out_valid/out_stall | status, expected_kind, depth
//
//  One character per cycle while in_stall is low; each result is registered.
//  The top kind sits in a register; the memory read port prefetches the
//  entry below it every cycle, so a pop finds the new top without waiting.
//  Reset clears count and error latch; stack entries need no clearing.
//  A two-entry result buffer keeps input flowing while output is stalled
//  until it fills; in_stall rises only when both entries are held.
// ---------------------------------------------------------------------------
`default_nettype none

module bracket_balance_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] ch,
    input  wire logic       end_of_text,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      status,
    output logic [2:0]      expected_kind,
    output logic [6:0]      depth
);

    localparam int CW = bbc_pkg::CNT_W;
    localparam int AW = bbc_pkg::ADDR_W;

    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    top_reg, top_next;
    logic          err_reg, err_next;

    logic             accept;
    logic             fifo_full;
    logic [1:0]       below_kind;
    logic [CW-1:0]    rd_count;
    logic [AW-1:0]    rd_addr;
    bbc_pkg::stk_wr_t wr;
    bbc_pkg::result_t res;
    bbc_pkg::result_t out_data;

    assign in_stall = fifo_full;
    assign accept   = in_valid && !fifo_full;

    // Stack update for one character
    always_comb
    begin
        logic [2:0]    op_k;
        logic [2:0]    cl_k;
        logic [2:0]    top_k;
        logic [2:0]    st;
        logic [2:0]    exp_k;
        logic [CW-1:0] cnt;

        op_k  = bbc_pkg::opener_kind(ch);
        cl_k  = bbc_pkg::closer_kind(ch);
        top_k = (count_reg == '0) ? bbc_pkg::KIND_NONE : ({1'b0, top_reg} + 3'd1);
        st    = bbc_pkg::ST_OK;
        exp_k = top_k;
        cnt   = count_reg;

        top_next = top_reg;
        err_next = err_reg;
        wr.en    = 1'b0;
        wr.addr  = count_reg[AW-1:0];
        wr.kind  = op_k[1:0] - 2'd1;

        if (!err_reg)
        begin
            if (op_k != bbc_pkg::KIND_NONE)
            begin
                if (count_reg == CW'(bbc_pkg::STACK_DEPTH))
                begin
                    st       = bbc_pkg::ST_OVERFLOW;
                    err_next = 1'b1;
                end
                else
                begin
                    wr.en    = accept;
                    cnt      = count_reg + CW'(1);
                    top_next = op_k[1:0] - 2'd1;
                    exp_k    = op_k;
                end
            end
            else if (cl_k != bbc_pkg::KIND_NONE)
            begin
                if (count_reg == '0)
                begin
                    st       = bbc_pkg::ST_EMPTY;
                    exp_k    = bbc_pkg::KIND_NONE;
                    err_next = 1'b1;
                end
                else if (top_k != cl_k)
                begin
                    st       = bbc_pkg::ST_WRONG;
                    err_next = 1'b1;
                end
                else
                begin
                    cnt      = count_reg - CW'(1);
                    top_next = below_kind;
                    exp_k    = (cnt == '0) ? bbc_pkg::KIND_NONE
                                           : ({1'b0, below_kind} + 3'd1);
                end
            end
        end

        // Final check at end of text
        if (end_of_text && (st == bbc_pkg::ST_OK) && !err_reg && (cnt != '0))
        begin
            st = bbc_pkg::ST_UNCLOSED;
        end

        res.status        = st;
        res.expected_kind = exp_k;
        res.depth         = 7'(cnt);

        count_next = cnt;
        if (end_of_text)
        begin
            count_next = '0;
            err_next   = 1'b0;
        end

        // Hold state when nothing transfers
        if (!accept)
        begin
            count_next = count_reg;
            top_next   = top_reg;
            err_next   = err_reg;
        end
    end

    // Prefetch the entry below the next top
    assign rd_count = count_next - CW'(2);
    assign rd_addr  = rd_count[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

    bbc_stack_mem u_mem (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_kind (below_kind)
    );

    bbc_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res),
        .full      (fifo_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign status        = out_data.status;
    assign expected_kind = out_data.expected_kind;
    assign depth         = out_data.depth;

endmodule

`default_nettype wire

>>> src/bbc_checker.sv
// ---------------------------------------------------------------------------
// bbc_checker
// Port-level checks on the bracket balance checker results.
// ---------------------------------------------------------------------------
`default_nettype none

module bbc_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [2:0] status,
    input  wire logic [2:0] expected_kind,
    input  wire logic [6:0] depth
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(expected_kind) && $stable(depth))
        else $error("stalled result changed");

    // Closer on empty stack leaves nothing open
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == bbc_pkg::ST_EMPTY) |->
            (expected_kind == bbc_pkg::KIND_NONE) && (depth == 7'd0))
        else $error("empty-stack closer with open brackets");

    // Unclosed report needs open brackets
    a_unclosed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == bbc_pkg::ST_UNCLOSED) |-> (depth != 7'd0))
        else $error("unclosed reported on empty stack");

    // Overflow only on a full stack
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == bbc_pkg::ST_OVERFLOW) |->
            (depth == 7'(bbc_pkg::STACK_DEPTH))
            && (expected_kind != bbc_pkg::KIND_NONE))
        else $error("overflow below full depth");

    // Empty stack shows no expected closer
    a_depth_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (depth == 7'd0) && (status != bbc_pkg::ST_OVERFLOW) |->
            (expected_kind == bbc_pkg::KIND_NONE))
        else $error("expected kind on empty stack");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (.*);

`default_nettype wire

>>> dv/bracket_balance_checker_test.sv
// ---------------------------------------------------------------------------
// bracket_balance_checker_test
// Self-checking testbench for the bracket balance checker. A scoreboard
// class tracks its own copy of the kind stack and error latch, predicts one
// result per accepted character, and compares each output transfer against
// the oldest prediction. Stimulus is a directed opening sequence followed by
// random texts: well-formed nesting, broken nesting, raw byte noise and
// full-depth texts that reach and overflow the stack. Both sides idle at
// random, with a long output hold-off and a full drain pause included.
// ---------------------------------------------------------------------------

module bracket_balance_checker_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int TARGET_CHARS  = 650;
    localparam int HOLD_CYCLES   = 40;
    localparam int TAIL_CYCLES   = 10;
    localparam int IDLE_LIMIT    = 2000;

    // Predicts results from accepted characters and checks output transfers
    class bracket_scoreboard;
        logic [2:0]       open_kinds [bbc_pkg::STACK_DEPTH];
        int               open_count;
        bit               err_held;
        bbc_pkg::result_t expected_q [$];
        int               errors;

        function new();
            open_count = 0;
            err_held   = 1'b0;
            errors     = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [2:0] opener_of(logic [7:0] c);
            case (c)
                bbc_pkg::CH_LPAREN:  return bbc_pkg::KIND_PAREN;
                bbc_pkg::CH_LBRACE:  return bbc_pkg::KIND_BRACE;
                bbc_pkg::CH_LSQUARE: return bbc_pkg::KIND_SQUARE;
                bbc_pkg::CH_LANGLE:  return bbc_pkg::KIND_ANGLE;
                default:             return bbc_pkg::KIND_NONE;
            endcase
        endfunction

        function logic [2:0] closer_of(logic [7:0] c);
            case (c)
                bbc_pkg::CH_RPAREN:  return bbc_pkg::KIND_PAREN;
                bbc_pkg::CH_RBRACE:  return bbc_pkg::KIND_BRACE;
                bbc_pkg::CH_RSQUARE: return bbc_pkg::KIND_SQUARE;
                bbc_pkg::CH_RANGLE:  return bbc_pkg::KIND_ANGLE;
                default:             return bbc_pkg::KIND_NONE;
            endcase
        endfunction

        function logic [2:0] top_kind();
            if (open_count == 0)
                return bbc_pkg::KIND_NONE;
            return open_kinds[open_count - 1];
        endfunction

        // Apply one accepted character and queue the result it must produce
        function void note_char(logic [7:0] c, logic eot);
            logic [2:0]       opn;
            logic [2:0]       cls;
            bit               held;
            bbc_pkg::result_t r;
            opn             = opener_of(c);
            cls             = closer_of(c);
            held            = err_held;
            r.status        = bbc_pkg::ST_OK;
            r.expected_kind = top_kind();
            if (!held)
            begin
                if (opn != bbc_pkg::KIND_NONE)
                begin
                    // push, or flag overflow on a full stack
                    if (open_count >= bbc_pkg::STACK_DEPTH)
                    begin
                        r.status = bbc_pkg::ST_OVERFLOW;
                        err_held = 1'b1;
                    end
                    else
                    begin
                        open_kinds[open_count] = opn;
                        open_count++;
                    end
                    r.expected_kind = top_kind();
                end
                else if (cls != bbc_pkg::KIND_NONE)
                begin
                    if (open_count == 0)
                    begin
                        r.status        = bbc_pkg::ST_EMPTY;
                        r.expected_kind = bbc_pkg::KIND_NONE;
                        err_held        = 1'b1;
                    end
                    else if (top_kind() != cls)
                    begin
                        // leave the stack alone, report the kind on top
                        r.status = bbc_pkg::ST_WRONG;
                        err_held = 1'b1;
                    end
                    else
                    begin
                        open_count--;
                        r.expected_kind = top_kind();
                    end
                end
            end
            // final check at end of text, skipped once an error was seen
            if (eot && r.status == bbc_pkg::ST_OK && !held && open_count != 0)
                r.status = bbc_pkg::ST_UNCLOSED;
            r.depth = 7'(open_count);
            expected_q.push_back(r);
            if (eot)
            begin
                open_count = 0;
                err_held   = 1'b0;
            end
        endfunction

        // Compare one output transfer against the oldest prediction
        function void check_result(bbc_pkg::result_t got);
            bbc_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected: status %0d kind %0d depth %0d",
                       got.status, got.expected_kind, got.depth);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.expected_kind !== want.expected_kind)
            begin
                $error("expected_kind: expected %0d, got %0d",
                       want.expected_kind, got.expected_kind);
                errors++;
            end
            if (got.depth !== want.depth)
            begin
                $error("depth: expected %0d, got %0d", want.depth, got.depth);
                errors++;
            end
        endfunction
    endclass

    typedef struct {
        logic [7:0] c;
        logic       eot;
    } text_char_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] ch;
    logic       end_of_text;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] status;
    logic [2:0] expected_kind;
    logic [6:0] depth;

    bracket_scoreboard sb;
    text_char_t        text_q [$];
    bit                calm;
    bit                hold_req;
    int                chars_sent;
    int                idle_cycles;

    bracket_balance_checker u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .ch            (ch),
        .end_of_text   (end_of_text),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .expected_kind (expected_kind),
        .depth         (depth)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Observe both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_char(ch, end_of_text);
            if (out_valid && !out_stall)
                sb.check_result(bbc_pkg::result_t'({status, expected_kind, depth}));
        end
    end

    // End the run when nothing transfers for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Output side: random stalls per result, plus one long hold-off on request
    initial
    begin
        int  wait_cycles;
        bit  got;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            wait_cycles = calm ? 0 : $urandom_range(0, 3);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(posedge clk);
                got = out_valid;
                @(negedge clk);
            end while (!got);
        end
    end

    function automatic bit is_bracket(logic [7:0] c);
        return sb.opener_of(c) != bbc_pkg::KIND_NONE
            || sb.closer_of(c) != bbc_pkg::KIND_NONE;
    endfunction

    function automatic logic [7:0] opener_char(logic [2:0] k);
        case (k)
            bbc_pkg::KIND_PAREN:  return bbc_pkg::CH_LPAREN;
            bbc_pkg::KIND_BRACE:  return bbc_pkg::CH_LBRACE;
            bbc_pkg::KIND_SQUARE: return bbc_pkg::CH_LSQUARE;
            default:              return bbc_pkg::CH_LANGLE;
        endcase
    endfunction

    function automatic logic [7:0] closer_char(logic [2:0] k);
        case (k)
            bbc_pkg::KIND_PAREN:  return bbc_pkg::CH_RPAREN;
            bbc_pkg::KIND_BRACE:  return bbc_pkg::CH_RBRACE;
            bbc_pkg::KIND_SQUARE: return bbc_pkg::CH_RSQUARE;
            default:              return bbc_pkg::CH_RANGLE;
        endcase
    endfunction

    function automatic logic [7:0] filler_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_bracket(c));
        return c;
    endfunction

    function automatic void add_char(logic [7:0] c, logic eot);
        text_char_t t;
        t.c   = c;
        t.eot = eot;
        text_q.push_back(t);
    endfunction

    // Nested text with random content; a broken one gets at most one defect
    function automatic void build_nested_text(int max_nest, bit broken);
        logic [2:0] open_q [$];
        logic [2:0] k;
        int         len;
        int         r;
        int         defect;
        len = $urandom_range(1, 24);
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (open_q.size() > 0 && r < 40)
            begin
                k = open_q.pop_back();
                add_char(closer_char(k), 1'b0);
            end
            else if (open_q.size() < max_nest && r < 80)
            begin
                k = 3'($urandom_range(1, 4));
                open_q.push_back(k);
                add_char(opener_char(k), 1'b0);
            end
            else
                add_char(filler_char(), 1'b0);
        end
        defect = broken ? $urandom_range(0, 2) : 3;
        if (defect == 0)
        begin
            // wrong closer, or a closer on an empty stack
            if (open_q.size() > 0)
                add_char(closer_char(3'((open_q[$] % 4) + 1)), 1'b0);
            else
                add_char(closer_char(3'($urandom_range(1, 4))), 1'b0);
        end
        if (defect != 1)
        begin
            while (open_q.size() > 0)
            begin
                k = open_q.pop_back();
                add_char(closer_char(k), 1'b0);
            end
        end
        if (defect == 2)
            add_char(closer_char(3'($urandom_range(1, 4))), 1'b0);
        if ($urandom_range(0, 1))
            text_q[$].eot = 1'b1;
        else
            add_char(filler_char(), 1'b1);
    endfunction

    // Fill the stack to the top, then either close it all or overflow it
    function automatic void build_full_text(bit overflow);
        logic [2:0] open_q [$];
        logic [2:0] k;
        for (int i = 0; i < bbc_pkg::STACK_DEPTH; i++)
        begin
            k = 3'($urandom_range(1, 4));
            open_q.push_back(k);
            add_char(opener_char(k), 1'b0);
        end
        if (overflow)
        begin
            add_char(opener_char(3'($urandom_range(1, 4))), 1'b0);
            add_char(closer_char(open_q[$]), 1'b0);
            add_char(filler_char(), 1'b1);
        end
        else
        begin
            while (open_q.size() > 0)
            begin
                k = open_q.pop_back();
                add_char(closer_char(k), open_q.size() == 0);
            end
        end
    endfunction

    // Raw bytes with random end-of-text marks
    function automatic void build_noise_text();
        int len;
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
            add_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        text_q[$].eot = 1'b1;
    endfunction

    // Offer one character and hold it until transfer; ends at a falling edge
    task automatic send_char(input logic [7:0] c, input logic e);
        int gap;
        bit done;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        ch          <= c;
        end_of_text <= e;
        in_valid    <= 1'b1;
        do
        begin
            @(posedge clk);
            done = !in_stall;
            @(negedge clk);
        end while (!done);
        chars_sent++;
    endtask

    task automatic play_text();
        text_char_t t;
        while (text_q.size() > 0)
        begin
            t = text_q.pop_front();
            send_char(t.c, t.eot);
        end
    endtask

    // Stop offering and wait for every predicted result
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int text_idx;
        int r;
        sb          = new();
        in_valid    = 1'b0;
        ch          = 8'h00;
        end_of_text = 1'b0;
        rst_n       = 1'b0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        chars_sent  = 0;
        idle_cycles = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: every kind pushed and popped, then the empty-stack, wrong-closer and unclosed paths
        add_char(8'h00, 1'b0);
        add_char(bbc_pkg::CH_LPAREN, 1'b0);
        add_char(bbc_pkg::CH_LBRACE, 1'b0);
        add_char(bbc_pkg::CH_LSQUARE, 1'b0);
        add_char(bbc_pkg::CH_LANGLE, 1'b0);
        add_char(bbc_pkg::CH_RANGLE, 1'b0);
        add_char(bbc_pkg::CH_RSQUARE, 1'b0);
        add_char(bbc_pkg::CH_RBRACE, 1'b0);
        add_char(bbc_pkg::CH_RPAREN, 1'b0);
        add_char(bbc_pkg::CH_RPAREN, 1'b0);     // closer on empty stack
        add_char(bbc_pkg::CH_LPAREN, 1'b0);     // ignored while latched
        add_char(8'hFF, 1'b1);                  // no unclosed report after an error
        add_char(bbc_pkg::CH_LSQUARE, 1'b0);
        add_char(bbc_pkg::CH_RPAREN, 1'b0);     // wrong closer
        add_char(8'h78, 1'b1);
        add_char(bbc_pkg::CH_LANGLE, 1'b0);
        add_char(8'h61, 1'b1);                  // unclosed at end
        add_char(bbc_pkg::CH_LBRACE, 1'b1);     // push on the last character
        add_char(bbc_pkg::CH_LPAREN, 1'b0);
        add_char(bbc_pkg::CH_RPAREN, 1'b1);     // balanced close on the last character
        add_char(bbc_pkg::CH_RBRACE, 1'b1);     // empty-stack closer on the last character
        add_char(bbc_pkg::CH_LPAREN, 1'b0);
        add_char(bbc_pkg::CH_RBRACE, 1'b1);     // wrong closer on the last character
        play_text();

        // random texts
        text_idx = 0;
        while (chars_sent < TARGET_CHARS)
        begin
            calm = (text_idx >= 20 && text_idx < 26);
            if (text_idx == 6)
                hold_req = 1'b1;
            if (text_idx == 12)
                drain();
            r = $urandom_range(0, 99);
            if (text_idx == 3)
                build_full_text(1'b0);
            else if (text_idx == 10)
                build_full_text(1'b1);
            else if (r < 60)
                build_nested_text($urandom_range(1, 8), 1'b0);
            else if (r < 85)
                build_nested_text($urandom_range(1, 8), 1'b1);
            else
                build_noise_text();
            play_text();
            text_idx++;
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
